// ===== rtl/core/lowt_pkg.sv =====
package lowt_pkg;

  localparam int unsigned TID_W = 16;
  localparam int unsigned LID_W = 32;

  // Operation codes on the request beat
  typedef enum logic [1:0] {
    FUNC_ACQUIRE  = 2'd0,
    FUNC_RELEASE  = 2'd1,
    FUNC_WAIT     = 2'd2,
    FUNC_SNAPSHOT = 2'd3
  } lowt_func_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_EDGE = 2'd1,
    KIND_END  = 2'd2
  } lowt_kind_e;

  typedef struct packed {
    lowt_func_e         func;
    logic [TID_W-1:0]   thread_id;
    logic [LID_W-1:0]   lock_id;
  } lowt_req_t;

  typedef struct packed {
    lowt_kind_e         kind;
    logic               table_full;
    logic [TID_W-1:0]   waiter_id;
    logic [TID_W-1:0]   owner_id;
    logic               last;
  } lowt_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load_req;     // latch the request beat
    logic lk_start;     // restart lock search
    logic lk_tgt_wait;  // lock search key from thread wait field
    logic lk_run;       // advance lock search
    logic th_start;     // restart thread search
    logic th_run;       // advance thread search
    logic commit;       // apply the update of the latched request
    logic tw_clr;       // rewind snapshot walk
    logic tw_rd;        // read next thread entry of the walk
    logic emit_ack;
    logic emit_edge;
    logic emit_end;
  } lowt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    lowt_func_e func;
    logic       lk_done;
    logic       lk_hit;
    logic       lk_owned;
    logic       th_done;
    logic       th_waits;
    logic       tw_more;
  } lowt_sts_t;

endpackage

// ===== rtl/core/lowt_dpath.sv =====
module lowt_dpath import lowt_pkg::*; #(
  parameter int unsigned LOCK_ENTRIES   = 32,
  parameter int unsigned THREAD_ENTRIES = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lowt_req_t req_i,
  input  lowt_cmd_t cmd_i,
  output lowt_sts_t sts_o,
  output lowt_rsp_t rsp_o,
  output logic      rsp_valid_o
);

  localparam int unsigned LCW = $clog2(LOCK_ENTRIES + 1);
  localparam int unsigned LAW = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
  localparam int unsigned TCW = $clog2(THREAD_ENTRIES + 1);
  localparam int unsigned TAW = (THREAD_ENTRIES > 1) ? $clog2(THREAD_ENTRIES) : 1;

  lowt_req_t req_q;

  // Lock table
  logic [LID_W-1:0] lk_key_mem [LOCK_ENTRIES];
  logic [TID_W-1:0] lk_own_mem [LOCK_ENTRIES];
  logic [LCW-1:0]   lk_ptr_q, lk_used_q;
  logic             lk_pend_q;
  logic [LAW-1:0]   lk_pidx_q;
  logic [LID_W-1:0] lk_tgt_q, lk_rkey_q;
  logic [TID_W-1:0] lk_rown_q;

  // Thread table
  logic [TID_W-1:0] th_key_mem  [THREAD_ENTRIES];
  logic [LID_W-1:0] th_wait_mem [THREAD_ENTRIES];
  logic [TCW-1:0]   th_ptr_q, th_used_q, tw_q;
  logic             th_pend_q;
  logic [TAW-1:0]   th_pidx_q;
  logic [TID_W-1:0] th_rkey_q;
  logic [LID_W-1:0] th_rwait_q;

  logic             lk_hit, lk_more, lk_done, lk_rd, lk_full, lk_we, lk_append;
  logic [LAW-1:0]   lk_waddr;
  logic [TID_W-1:0] lk_wown;
  logic             th_hit, th_more, th_done, th_rd, th_full, th_we, th_append;
  logic [TAW-1:0]   th_waddr, th_raddr;
  logic [LID_W-1:0] th_wwait;
  logic             tw_more, full_flag;
  logic             is_acq, is_rel, is_wait;
  lowt_rsp_t        rsp_d, rsp_q;
  logic             rsp_valid_q;

  // Request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_i;
    end
  end

  assign is_acq  = (req_q.func == FUNC_ACQUIRE);
  assign is_rel  = (req_q.func == FUNC_RELEASE);
  assign is_wait = (req_q.func == FUNC_WAIT);

  // Lock search: one read issued per cycle, compared in the cycle after the read
  always_comb begin
    lk_hit  = lk_pend_q && (lk_rkey_q == lk_tgt_q);
    lk_more = (lk_ptr_q < lk_used_q);
    lk_done = lk_hit || (!lk_pend_q && !lk_more);
    lk_rd   = cmd_i.lk_run && !lk_hit && lk_more;
    lk_full = (lk_used_q == LCW'(LOCK_ENTRIES));
  end

  // Thread search, same scheme; read port shared with the snapshot walk
  always_comb begin
    th_hit   = th_pend_q && (th_rkey_q == req_q.thread_id);
    th_more  = (th_ptr_q < th_used_q);
    th_done  = th_hit || (!th_pend_q && !th_more);
    th_full  = (th_used_q == TCW'(THREAD_ENTRIES));
    tw_more  = (tw_q < th_used_q);
    th_rd    = (cmd_i.th_run && !th_hit && th_more) || cmd_i.tw_rd;
    th_raddr = cmd_i.tw_rd ? tw_q[TAW-1:0] : th_ptr_q[TAW-1:0];
  end

  // Update decode: hit rewrites the entry, an acquire or wait miss appends unless full
  always_comb begin
    lk_append = cmd_i.commit && is_acq && !lk_hit && !lk_full;
    lk_we     = (cmd_i.commit && is_acq && lk_hit) || lk_append ||
                (cmd_i.commit && is_rel && lk_hit);
    lk_waddr  = lk_hit ? lk_pidx_q : lk_used_q[LAW-1:0];
    lk_wown   = is_acq ? req_q.thread_id : '0;
    th_append = cmd_i.commit && (is_acq || is_wait) && !th_hit && !th_full;
    th_we     = (cmd_i.commit && (is_acq || is_wait) && th_hit) || th_append;
    th_waddr  = th_hit ? th_pidx_q : th_used_q[TAW-1:0];
    th_wwait  = is_wait ? req_q.lock_id : '0;
    full_flag = (is_acq && ((!lk_hit && lk_full) || (!th_hit && th_full))) ||
                (is_wait && !th_hit && th_full);
  end

  // Lock search control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk_ptr_q  <= '0;
      lk_pend_q <= 1'b0;
      lk_used_q <= '0;
    end else begin
      if (cmd_i.lk_start) begin
        lk_ptr_q  <= '0;
        lk_pend_q <= 1'b0;
      end else if (cmd_i.lk_run && !lk_hit) begin
        if (lk_more) begin
          lk_ptr_q  <= lk_ptr_q + 1'b1;
          lk_pend_q <= 1'b1;
        end else begin
          lk_pend_q <= 1'b0;
        end
      end
      if (lk_append) begin
        lk_used_q <= lk_used_q + 1'b1;
      end
    end
  end

  // Lock memory and search payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.lk_start) begin
      lk_tgt_q <= cmd_i.lk_tgt_wait ? th_rwait_q : req_q.lock_id;
    end
    if (lk_rd) begin
      lk_rkey_q <= lk_key_mem[lk_ptr_q[LAW-1:0]];
      lk_rown_q <= lk_own_mem[lk_ptr_q[LAW-1:0]];
      lk_pidx_q <= lk_ptr_q[LAW-1:0];
    end
    if (lk_we) begin
      lk_key_mem[lk_waddr] <= req_q.lock_id;
      lk_own_mem[lk_waddr] <= lk_wown;
    end
  end

  // Thread search and walk control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      th_ptr_q  <= '0;
      th_pend_q <= 1'b0;
      th_used_q <= '0;
      tw_q      <= '0;
    end else begin
      if (cmd_i.th_start) begin
        th_ptr_q  <= '0;
        th_pend_q <= 1'b0;
      end else if (cmd_i.th_run && !th_hit) begin
        if (th_more) begin
          th_ptr_q  <= th_ptr_q + 1'b1;
          th_pend_q <= 1'b1;
        end else begin
          th_pend_q <= 1'b0;
        end
      end
      if (th_append) begin
        th_used_q <= th_used_q + 1'b1;
      end
      if (cmd_i.tw_clr) begin
        tw_q <= '0;
      end else if (cmd_i.tw_rd) begin
        tw_q <= tw_q + 1'b1;
      end
    end
  end

  // Thread memory
  always_ff @(posedge clk_i) begin
    if (th_rd) begin
      th_rkey_q  <= th_key_mem[th_raddr];
      th_rwait_q <= th_wait_mem[th_raddr];
    end
    if (cmd_i.th_run && !th_hit && th_more) begin
      th_pidx_q <= th_ptr_q[TAW-1:0];
    end
    if (th_we) begin
      th_key_mem[th_waddr]  <= req_q.thread_id;
      th_wait_mem[th_waddr] <= th_wwait;
    end
  end

  // Result beat
  always_comb begin
    rsp_d = '0;
    if (cmd_i.emit_ack) begin
      rsp_d.kind       = KIND_ACK;
      rsp_d.table_full = full_flag;
      rsp_d.last       = 1'b1;
    end else if (cmd_i.emit_edge) begin
      rsp_d.kind      = KIND_EDGE;
      rsp_d.waiter_id = th_rkey_q;
      rsp_d.owner_id  = lk_rown_q;
    end else if (cmd_i.emit_end) begin
      rsp_d.kind = KIND_END;
      rsp_d.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= cmd_i.emit_ack || cmd_i.emit_edge || cmd_i.emit_end;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    sts_o.func     = req_q.func;
    sts_o.lk_done  = lk_done;
    sts_o.lk_hit   = lk_hit;
    sts_o.lk_owned = (lk_rown_q != '0);
    sts_o.th_done  = th_done;
    sts_o.th_waits = (th_rwait_q != '0);
    sts_o.tw_more  = tw_more;
  end

endmodule

// ===== rtl/core/lowt_ctrl.sv =====
module lowt_ctrl import lowt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  lowt_sts_t sts_i,
  output lowt_cmd_t cmd_o,
  output logic      busy_o
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_DISP    = 7'b0000010,
    S_SRCH    = 7'b0000100,
    S_COMMIT  = 7'b0001000,
    S_SN_RD   = 7'b0010000,
    S_SN_CHK  = 7'b0100000,
    S_SN_LOOK = 7'b1000000
  } lowt_state_e;

  lowt_state_e state_q, state_d;

  assign busy_o = (state_q != S_IDLE);

  // Sequencer
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.func == FUNC_SNAPSHOT) begin
          cmd_o.tw_clr = 1'b1;
          state_d      = S_SN_RD;
        end else begin
          cmd_o.lk_start = 1'b1;
          cmd_o.th_start = 1'b1;
          state_d        = S_SRCH;
        end
      end
      // both tables searched side by side
      S_SRCH: begin
        cmd_o.lk_run = 1'b1;
        cmd_o.th_run = 1'b1;
        if (sts_i.lk_done && sts_i.th_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit   = 1'b1;
        cmd_o.emit_ack = 1'b1;
        state_d        = S_IDLE;
      end
      // snapshot: walk threads in insertion order
      S_SN_RD: begin
        if (sts_i.tw_more) begin
          cmd_o.tw_rd = 1'b1;
          state_d     = S_SN_CHK;
        end else begin
          cmd_o.emit_end = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_SN_CHK: begin
        if (sts_i.th_waits) begin
          cmd_o.lk_start    = 1'b1;
          cmd_o.lk_tgt_wait = 1'b1;
          state_d           = S_SN_LOOK;
        end else begin
          state_d = S_SN_RD;
        end
      end
      S_SN_LOOK: begin
        cmd_o.lk_run = 1'b1;
        if (sts_i.lk_done) begin
          cmd_o.emit_edge = sts_i.lk_hit && sts_i.lk_owned;
          state_d         = S_SN_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/lock_owner_wait_tracker.sv =====
// Lock owner / wait tracker. A request beat is taken when start is high and busy
// is low; busy stays high until the cycle in which its last result appears on
// rsp_o. Results appear on rsp_o for one cycle each, marked by rsp_valid_o, with
// no way to hold them off; last marks the final result of a request. Acquire,
// release and wait each give one ack after a linear search of the lock and thread
// tables, which run in parallel at one entry per cycle. A snapshot reads every
// thread entry and, for each waiting thread, searches the lock table one entry
// per cycle. Search speed is set by the single read port of each table memory.
module lock_owner_wait_tracker import lowt_pkg::*; #(
  parameter int unsigned LOCK_ENTRIES   = 32,
  parameter int unsigned THREAD_ENTRIES = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  lowt_req_t req_i,
  output lowt_rsp_t rsp_o,
  output logic      rsp_valid_o
);

  lowt_cmd_t cmd;
  lowt_sts_t sts;

  lowt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  lowt_dpath #(
    .LOCK_ENTRIES  (LOCK_ENTRIES),
    .THREAD_ENTRIES(THREAD_ENTRIES)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_o      (rsp_o),
    .rsp_valid_o(rsp_valid_o)
  );

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lowt_pkg::*;

  localparam int LOCK_N         = 32;
  localparam int THREAD_N       = 32;
  localparam int RANDOM_ITEMS   = 111;
  localparam int POOL_N         = 40;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 100;

  // One row of the directed table; typed rows carry their own expected beat
  typedef struct packed {
    lowt_req_t req;
    logic      typed;
    lowt_rsp_t rsp;
  } dir_row_t;

  function automatic dir_row_t row(lowt_func_e f, logic [TID_W-1:0] tid,
                                   logic [LID_W-1:0] lid, logic typed, lowt_kind_e k);
    dir_row_t r;
    r.req.func           = f;
    r.req.thread_id      = tid;
    r.req.lock_id        = lid;
    r.typed              = typed;
    r.rsp.kind           = k;
    r.rsp.table_full     = 1'b0;
    r.rsp.waiter_id      = '0;
    r.rsp.owner_id       = '0;
    r.rsp.last           = 1'b1;
    return r;
  endfunction

  // Empty tables, zero ids, all-ones ids, waits on free / unknown / zero locks
  localparam int DIR_N = 19;
  localparam dir_row_t DIRECTED [DIR_N] = '{
    row(FUNC_SNAPSHOT, 16'h0000, 32'h0000_0000, 1'b1, KIND_END),
    row(FUNC_RELEASE,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, KIND_ACK),
    row(FUNC_ACQUIRE,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, KIND_ACK),
    row(FUNC_ACQUIRE,  16'h0000, 32'h0000_0000, 1'b1, KIND_ACK),
    row(FUNC_WAIT,     16'h0001, 32'hFFFF_FFFF, 1'b1, KIND_ACK),
    row(FUNC_WAIT,     16'h0002, 32'h0000_0000, 1'b1, KIND_ACK),
    row(FUNC_WAIT,     16'h0003, 32'h5A5A_0001, 1'b1, KIND_ACK),
    row(FUNC_SNAPSHOT, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, KIND_END),
    row(FUNC_ACQUIRE,  16'h8000, 32'h8000_0000, 1'b1, KIND_ACK),
    row(FUNC_WAIT,     16'h0000, 32'h8000_0000, 1'b1, KIND_ACK),
    row(FUNC_WAIT,     16'h0004, 32'h0000_0000, 1'b1, KIND_ACK),
    row(FUNC_SNAPSHOT, 16'h1234, 32'h0000_0001, 1'b0, KIND_END),
    row(FUNC_RELEASE,  16'h0000, 32'hFFFF_FFFF, 1'b1, KIND_ACK),
    row(FUNC_SNAPSHOT, 16'h0000, 32'h0000_0000, 1'b0, KIND_END),
    row(FUNC_ACQUIRE,  16'h0001, 32'h1234_5678, 1'b1, KIND_ACK),
    row(FUNC_ACQUIRE,  16'h5555, 32'hAAAA_AAAA, 1'b1, KIND_ACK),
    row(FUNC_WAIT,     16'hAAAA, 32'h1234_5678, 1'b1, KIND_ACK),
    row(FUNC_WAIT,     16'h0001, 32'hAAAA_AAAA, 1'b1, KIND_ACK),
    row(FUNC_SNAPSHOT, 16'h7FFF, 32'h7FFF_FFFF, 1'b0, KIND_END)
  };

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  lowt_req_t req_i;
  lowt_rsp_t rsp_o;
  logic      rsp_valid_o;

  // Sideband that travels with the request beat
  logic      req_typed;
  lowt_rsp_t req_typed_rsp;

  lock_owner_wait_tracker #(
    .LOCK_ENTRIES   (LOCK_N),
    .THREAD_ENTRIES (THREAD_N)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Shadow copy of the lock and thread tables
  logic [LID_W-1:0] lk_key   [LOCK_N];
  logic [TID_W-1:0] lk_owner [LOCK_N];
  int               lk_cnt;
  logic [TID_W-1:0] th_key   [THREAD_N];
  logic [LID_W-1:0] th_wait  [THREAD_N];
  int               th_cnt;

  lowt_rsp_t step_rsp[$];
  lowt_rsp_t pending_rsp[$];
  int        mismatches;
  int        sent;
  int        accepted_cnt;
  int        quiet_cycles;

  function automatic int find_lock(logic [LID_W-1:0] key);
    for (int i = 0; i < lk_cnt; i++)
      if (lk_key[i] == key) return i;
    return -1;
  endfunction

  function automatic int find_thread(logic [TID_W-1:0] key);
    for (int i = 0; i < th_cnt; i++)
      if (th_key[i] == key) return i;
    return -1;
  endfunction

  // Apply one request to the shadow tables; beats it should produce go to step_rsp
  task automatic apply_lock_event(input lowt_req_t r);
    int        ls;
    int        ts;
    logic      full;
    lowt_rsp_t b;
    step_rsp.delete();
    full        = 1'b0;
    b.kind       = KIND_ACK;
    b.table_full = 1'b0;
    b.waiter_id  = '0;
    b.owner_id   = '0;
    b.last       = 1'b1;
    case (r.func)
      FUNC_ACQUIRE: begin
        ls = find_lock(r.lock_id);
        if (ls < 0 && lk_cnt < LOCK_N) begin
          ls = lk_cnt;
          lk_key[ls] = r.lock_id;
          lk_cnt++;
        end
        if (ls >= 0) lk_owner[ls] = r.thread_id;
        else full = 1'b1;
        ts = find_thread(r.thread_id);
        if (ts < 0 && th_cnt < THREAD_N) begin
          ts = th_cnt;
          th_key[ts] = r.thread_id;
          th_cnt++;
        end
        if (ts >= 0) th_wait[ts] = '0;
        else full = 1'b1;
      end
      FUNC_RELEASE: begin
        ls = find_lock(r.lock_id);
        if (ls >= 0) lk_owner[ls] = '0;
      end
      FUNC_WAIT: begin
        ts = find_thread(r.thread_id);
        if (ts < 0 && th_cnt < THREAD_N) begin
          ts = th_cnt;
          th_key[ts] = r.thread_id;
          th_cnt++;
        end
        if (ts >= 0) th_wait[ts] = r.lock_id;
        else full = 1'b1;
      end
      default: begin
        // walk threads in insertion order, one edge per blocked waiter
        for (int i = 0; i < th_cnt; i++) begin
          if (th_wait[i] != '0) begin
            ls = find_lock(th_wait[i]);
            if (ls >= 0 && lk_owner[ls] != '0) begin
              b.kind      = KIND_EDGE;
              b.waiter_id = th_key[i];
              b.owner_id  = lk_owner[ls];
              b.last      = 1'b0;
              step_rsp.push_back(b);
            end
          end
        end
        b.kind      = KIND_END;
        b.waiter_id = '0;
        b.owner_id  = '0;
        b.last      = 1'b1;
      end
    endcase
    b.table_full = full;
    step_rsp.push_back(b);
  endtask

  // Result check first, then take any request beat accepted at this edge
  always @(posedge clk_i) begin : monitor
    lowt_rsp_t want;
    if (rst_ni) begin
      if (rsp_valid_o === 1'b1) begin
        if (pending_rsp.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result beat: kind=%0d full=%b waiter=%h owner=%h last=%b",
                     rsp_o.kind, rsp_o.table_full, rsp_o.waiter_id, rsp_o.owner_id,
                     rsp_o.last);
          mismatches++;
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_o.kind !== want.kind || rsp_o.table_full !== want.table_full ||
              rsp_o.waiter_id !== want.waiter_id || rsp_o.owner_id !== want.owner_id ||
              rsp_o.last !== want.last) begin
            if (mismatches < 10)
              $display("result mismatch: exp kind=%0d full=%b waiter=%h owner=%h last=%b, %s",
                       want.kind, want.table_full, want.waiter_id, want.owner_id, want.last,
                       $sformatf("got kind=%0d full=%b waiter=%h owner=%h last=%b",
                                 rsp_o.kind, rsp_o.table_full, rsp_o.waiter_id,
                                 rsp_o.owner_id, rsp_o.last));
            mismatches++;
          end
        end
      end
      if (start && busy === 1'b0) begin
        apply_lock_event(req_i);
        if (req_typed) pending_rsp.push_back(req_typed_rsp);
        else foreach (step_rsp[i]) pending_rsp.push_back(step_rsp[i]);
        accepted_cnt++;
      end
    end
  end

  // Watchdog: cycles with neither a request nor a result beat
  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || rsp_valid_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  logic             steady;
  logic [TID_W-1:0] thr_pool [POOL_N];
  logic [LID_W-1:0] lk_pool  [POOL_N];

  // Present one request beat and hold it until the block takes it
  task automatic issue(input lowt_req_t r, input logic typed, input lowt_rsp_t typed_rsp);
    start         <= 1'b1;
    req_i         <= r;
    req_typed     <= typed;
    req_typed_rsp <= typed_rsp;
    sent++;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // Sender gap: mostly none or short, now and then long
  task automatic hold_off();
    int g;
    int roll;
    roll = $urandom_range(0, 19);
    if (steady || roll < 11) g = 0;
    else if (roll < 18) g = $urandom_range(1, 3);
    else g = $urandom_range(10, 40);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Random request; the set of ids in play grows so both tables fill up
  function automatic lowt_req_t random_req(int n);
    lowt_req_t r;
    int        active;
    int        roll;
    active = (6 + n / 2 < POOL_N - 1) ? 6 + n / 2 : POOL_N - 1;
    roll   = $urandom_range(0, 19);
    if (roll < 7)       r.func = FUNC_ACQUIRE;
    else if (roll < 14) r.func = FUNC_WAIT;
    else if (roll < 17) r.func = FUNC_RELEASE;
    else                r.func = FUNC_SNAPSHOT;
    if ($urandom_range(0, 4) != 0) r.thread_id = thr_pool[$urandom_range(0, active)];
    else r.thread_id = TID_W'($urandom_range(0, 65535));
    roll = $urandom_range(0, 9);
    if (roll < 8)       r.lock_id = lk_pool[$urandom_range(0, active)];
    else if (roll == 8) r.lock_id = '0;
    else                r.lock_id = $urandom;
    return r;
  endfunction

  initial begin
    lowt_req_t r;
    mismatches    = 0;
    sent          = 0;
    accepted_cnt  = 0;
    lk_cnt        = 0;
    th_cnt        = 0;
    steady        = 1'b0;
    quiet_cycles  = 0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    req_i         = '0;
    req_typed     = 1'b0;
    req_typed_rsp = '0;
    thr_pool[0] = 16'h0000;
    thr_pool[1] = 16'hFFFF;
    lk_pool[0]  = 32'hFFFF_FFFF;
    lk_pool[1]  = 32'h0000_0001;
    for (int i = 2; i < POOL_N; i++) begin
      thr_pool[i] = TID_W'($urandom_range(1, 65535));
      lk_pool[i]  = $urandom;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (DIRECTED[i]) begin
      hold_off();
      issue(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].rsp);
    end

    // Random traffic, gap style re-rolled every 16 beats
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 16 == 0) steady = ($urandom_range(0, 3) == 0);
      r = random_req(n);
      hold_off();
      issue(r, 1'b0, '0);
    end
    start <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (accepted_cnt < sent || pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
